[rtl/charge_current_ramp_encoder_defines.svh]
// ----------------------------------------------------------------------------
// Charge current ramp encoder assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef CHARGE_CURRENT_RAMP_ENCODER_DEFINES_SVH
`define CHARGE_CURRENT_RAMP_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CCRE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccre port check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CCRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccre port check failed");

`endif

[rtl/ccre_pkg.sv]
// ----------------------------------------------------------------------------
// Charge current ramp encoder package
// Transaction types, register indexes and encoder constants.
// ----------------------------------------------------------------------------
package ccre_pkg;

  localparam int unsigned CUR_W  = 22;
  localparam int unsigned STEP_W = 20;
  localparam int unsigned CODE_W = 6;
  localparam int unsigned MA_W   = 13;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_CHIP_VARIANT = 2'd0;
  localparam logic [1:0] CFG_MIN_CURRENT  = 2'd1;
  localparam logic [1:0] CFG_RAMP_STEP    = 2'd2;

  // Input transaction modes
  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [STEP_W-1:0] RAMP_STEP_RESET = 20'd100000;

  // Linear encoding and mA divisors
  localparam longint unsigned LINEAR_STEP_UA = 60000;
  localparam longint unsigned UA_PER_MA      = 1000;

  // Reciprocal divide of a 22-bit current: q = (ua * MUL) >> DIV_SHIFT.
  // A shift of CUR_W + clog2(larger divisor) keeps the quotient exact for all inputs.
  localparam int unsigned DIV_SHIFT = CUR_W + (($clog2(LINEAR_STEP_UA) > $clog2(UA_PER_MA)) ?
                                               $clog2(LINEAR_STEP_UA) : $clog2(UA_PER_MA));
  localparam int unsigned DIV_MUL_W = 32;
  localparam longint unsigned LIN_MUL_L =
    ((64'd1 << DIV_SHIFT) + LINEAR_STEP_UA - 1) / LINEAR_STEP_UA;
  localparam longint unsigned MA_MUL_L =
    ((64'd1 << DIV_SHIFT) + UA_PER_MA - 1) / UA_PER_MA;
  localparam logic [DIV_MUL_W-1:0] LIN_MUL = LIN_MUL_L[DIV_MUL_W-1:0];
  localparam logic [DIV_MUL_W-1:0] MA_MUL  = MA_MUL_L[DIV_MUL_W-1:0];

  localparam logic [CODE_W-1:0] LIN_CODE_MAX = 6'd63;

  // Segment encoding: offsets stay below 2^12, so a shift of 19 is exact
  // for every segment divisor up to 120.
  localparam int unsigned SEG_OFF_W = 12;
  localparam int unsigned SEG_MUL_W = 17;
  localparam int unsigned SEG_SHIFT = 19;
  localparam int unsigned SEG_MUL5_I   = ((1 << SEG_SHIFT) + 4)   / 5;
  localparam int unsigned SEG_MUL10_I  = ((1 << SEG_SHIFT) + 9)   / 10;
  localparam int unsigned SEG_MUL20_I  = ((1 << SEG_SHIFT) + 19)  / 20;
  localparam int unsigned SEG_MUL30_I  = ((1 << SEG_SHIFT) + 29)  / 30;
  localparam int unsigned SEG_MUL60_I  = ((1 << SEG_SHIFT) + 59)  / 60;
  localparam int unsigned SEG_MUL120_I = ((1 << SEG_SHIFT) + 119) / 120;
  localparam logic [SEG_MUL_W-1:0] SEG_MUL5   = SEG_MUL5_I[SEG_MUL_W-1:0];
  localparam logic [SEG_MUL_W-1:0] SEG_MUL10  = SEG_MUL10_I[SEG_MUL_W-1:0];
  localparam logic [SEG_MUL_W-1:0] SEG_MUL20  = SEG_MUL20_I[SEG_MUL_W-1:0];
  localparam logic [SEG_MUL_W-1:0] SEG_MUL30  = SEG_MUL30_I[SEG_MUL_W-1:0];
  localparam logic [SEG_MUL_W-1:0] SEG_MUL60  = SEG_MUL60_I[SEG_MUL_W-1:0];
  localparam logic [SEG_MUL_W-1:0] SEG_MUL120 = SEG_MUL120_I[SEG_MUL_W-1:0];

  // Segment base codes
  localparam logic [CODE_W-1:0] SEG_CODE_8  = 6'h08;
  localparam logic [CODE_W-1:0] SEG_CODE_15 = 6'h0F;
  localparam logic [CODE_W-1:0] SEG_CODE_23 = 6'h17;
  localparam logic [CODE_W-1:0] SEG_CODE_32 = 6'h20;
  localparam logic [CODE_W-1:0] SEG_CODE_48 = 6'h30;
  localparam logic [CODE_W-1:0] SEG_CODE_MAX = 6'h3D;

  typedef struct packed {
    logic              mode;
    logic [CUR_W-1:0]  requested_current_ua;
  } in_item_t;

  typedef struct packed {
    logic              code_written;
    logic [CODE_W-1:0] charge_code;
    logic [CUR_W-1:0]  applied_current_ua;
    logic              on_target;
  } out_item_t;

endpackage

[rtl/charge_current_ramp_encoder.sv]
// ----------------------------------------------------------------------------
// Charge current ramp encoder
// Slew-limited charge current setter with a 6-bit charger code encoder.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | in_item  (mode, requested_current_ua)
//  out     | out_valid / out_stall| out_item (code_written, charge_code,
//          |                      |           applied_current_ua, on_target)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
//  One transaction per cycle in and out while out_stall is low; a result
//  passes the input register, ramp step, current divide and code encode
//  stages in turn after its input is accepted. The ramp step stage owns the
//  applied/target state, so each item sees the state its predecessor left.
//  rst is synchronous: it empties the pipeline, zeroes the currents and
//  the held code, and reloads the register defaults.
//  A stalled output holds its transaction; the stages behind it keep
//  filling until each is occupied, then in_stall rises.
// ----------------------------------------------------------------------------
module charge_current_ramp_encoder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ccre_pkg::in_item_t      in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ccre_pkg::out_item_t     out_item,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [ccre_pkg::CUR_W-1:0] cfg_data
);

  // Configuration registers
  logic                             chip_variant;
  logic [ccre_pkg::CUR_W-1:0]       min_current_ua;
  logic [ccre_pkg::STEP_W-1:0]      ramp_step_ua;

  // Ramp state
  logic [ccre_pkg::CUR_W-1:0]       applied_current;
  logic [ccre_pkg::CUR_W-1:0]       target_current;
  logic [ccre_pkg::CODE_W-1:0]      last_code;

  // Stage 1: input register
  logic                             s1_valid;
  ccre_pkg::in_item_t               s1_item;

  // Stage 2: ramp step result
  logic                             s2_valid;
  logic                             s2_written;
  logic [ccre_pkg::CUR_W-1:0]       s2_applied;
  logic                             s2_done;

  // Stage 3: divided current (mA or linear steps)
  logic                             s3_valid;
  logic                             s3_written;
  logic [ccre_pkg::CUR_W-1:0]       s3_applied;
  logic                             s3_done;
  logic [ccre_pkg::MA_W-1:0]        s3_quot;

  // Stage advance enables, back to front
  logic adv_out, adv3, adv2, adv1;

  assign adv_out  = !out_valid || !out_stall;
  assign adv3     = !s3_valid  || adv_out;
  assign adv2     = !s2_valid  || adv3;
  assign adv1     = !s1_valid  || adv2;
  assign in_stall = !adv1;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration writes; an index past the list is dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_variant   <= 1'b0;
      min_current_ua <= '0;
      ramp_step_ua   <= ccre_pkg::RAMP_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ccre_pkg::CFG_CHIP_VARIANT: chip_variant   <= cfg_data[0];
        ccre_pkg::CFG_MIN_CURRENT:  min_current_ua <= cfg_data;
        ccre_pkg::CFG_RAMP_STEP:    ramp_step_ua   <= cfg_data[ccre_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the input transaction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_item <= in_item;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: ramp step. A set-target item clamps the request up to the
  // minimum first; a tick keeps the old target. Rise by at most one ramp
  // step (zero step counts as one), drop to the target at once.
  // --------------------------------------------------------------------------
  logic [ccre_pkg::CUR_W-1:0]  target_next;
  logic [ccre_pkg::CUR_W-1:0]  applied_next;
  logic [ccre_pkg::STEP_W-1:0] step_eff;
  logic [ccre_pkg::CUR_W:0]    step_sum;
  logic                        step_written;

  always_comb begin
    if (s1_item.mode == ccre_pkg::MODE_SET) begin
      target_next = (s1_item.requested_current_ua < min_current_ua) ?
                    min_current_ua : s1_item.requested_current_ua;
    end else begin
      target_next = target_current;
    end

    step_eff = (ramp_step_ua == '0) ? ccre_pkg::STEP_W'(1) : ramp_step_ua;
    step_sum = {1'b0, applied_current}
             + {{(ccre_pkg::CUR_W + 1 - ccre_pkg::STEP_W){1'b0}}, step_eff};

    priority if (applied_current < target_next) begin
      step_written = 1'b1;
      applied_next = (step_sum > {1'b0, target_next}) ?
                     target_next : step_sum[ccre_pkg::CUR_W-1:0];
    end else if (applied_current > target_next) begin
      step_written = 1'b1;
      applied_next = target_next;
    end else begin
      step_written = 1'b0;
      applied_next = applied_current;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid        <= 1'b0;
      applied_current <= '0;
      target_current  <= '0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        applied_current <= applied_next;
        target_current  <= target_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_written <= step_written;
      s2_applied <= applied_next;
      s2_done    <= (applied_next == target_next);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: one reciprocal multiply, by 1/1000 for the segment map or by
  // 1/LINEAR_STEP_UA for the linear code
  // --------------------------------------------------------------------------
  logic [ccre_pkg::DIV_MUL_W-1:0]                div_mul;
  logic [ccre_pkg::CUR_W+ccre_pkg::DIV_MUL_W-1:0] div_prod;
  logic [ccre_pkg::MA_W-1:0]                     div_quot;

  always_comb begin
    div_mul  = chip_variant ? ccre_pkg::MA_MUL : ccre_pkg::LIN_MUL;
    div_prod = {{ccre_pkg::DIV_MUL_W{1'b0}}, s2_applied}
             * {{ccre_pkg::CUR_W{1'b0}}, div_mul};
    div_quot = div_prod[ccre_pkg::DIV_SHIFT +: ccre_pkg::MA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      s3_written <= s2_written;
      s3_applied <= s2_applied;
      s3_done    <= s2_done;
      s3_quot    <= div_quot;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: encode. The segment map picks a base code and an offset from
  // the mA value, then divides the offset by the segment width; the flat
  // gaps between segments use a zero offset. Linear code saturates at 63.
  // --------------------------------------------------------------------------
  logic [ccre_pkg::CODE_W-1:0]    seg_base;
  logic [ccre_pkg::MA_W-1:0]      seg_off_full;
  logic [ccre_pkg::SEG_MUL_W-1:0] seg_mul;
  logic [ccre_pkg::SEG_OFF_W+ccre_pkg::SEG_MUL_W-1:0] seg_prod;
  logic [ccre_pkg::CODE_W-1:0]    seg_code;
  logic [ccre_pkg::CODE_W-1:0]    lin_code;
  logic [ccre_pkg::CODE_W-1:0]    enc_code;
  logic [ccre_pkg::CODE_W-1:0]    code_next;

  always_comb begin
    seg_mul = ccre_pkg::SEG_MUL5;
    priority if (s3_quot <= 13'd40) begin
      seg_base = '0;                    seg_off_full = s3_quot;
      seg_mul  = ccre_pkg::SEG_MUL5;
    end else if (s3_quot < 13'd50) begin
      seg_base = ccre_pkg::SEG_CODE_8;  seg_off_full = '0;
    end else if (s3_quot <= 13'd110) begin
      seg_base = ccre_pkg::SEG_CODE_8;  seg_off_full = s3_quot - 13'd40;
      seg_mul  = ccre_pkg::SEG_MUL10;
    end else if (s3_quot < 13'd130) begin
      seg_base = ccre_pkg::SEG_CODE_15; seg_off_full = '0;
    end else if (s3_quot <= 13'd270) begin
      seg_base = ccre_pkg::SEG_CODE_15; seg_off_full = s3_quot - 13'd110;
      seg_mul  = ccre_pkg::SEG_MUL20;
    end else if (s3_quot < 13'd300) begin
      seg_base = ccre_pkg::SEG_CODE_23; seg_off_full = '0;
    end else if (s3_quot <= 13'd540) begin
      seg_base = ccre_pkg::SEG_CODE_23; seg_off_full = s3_quot - 13'd270;
      seg_mul  = ccre_pkg::SEG_MUL30;
    end else if (s3_quot < 13'd600) begin
      seg_base = ccre_pkg::SEG_CODE_32; seg_off_full = '0;
    end else if (s3_quot <= 13'd1500) begin
      seg_base = ccre_pkg::SEG_CODE_32; seg_off_full = s3_quot - 13'd540;
      seg_mul  = ccre_pkg::SEG_MUL60;
    end else if (s3_quot < 13'd1620) begin
      seg_base = ccre_pkg::SEG_CODE_48; seg_off_full = '0;
    end else if (s3_quot <= 13'd2940) begin
      seg_base = ccre_pkg::SEG_CODE_48; seg_off_full = s3_quot - 13'd1500;
      seg_mul  = ccre_pkg::SEG_MUL120;
    end else begin
      seg_base = ccre_pkg::SEG_CODE_MAX; seg_off_full = '0;
    end

    seg_prod = {{ccre_pkg::SEG_MUL_W{1'b0}}, seg_off_full[ccre_pkg::SEG_OFF_W-1:0]}
             * {{ccre_pkg::SEG_OFF_W{1'b0}}, seg_mul};
    seg_code = seg_base + seg_prod[ccre_pkg::SEG_SHIFT +: ccre_pkg::CODE_W];

    lin_code = (s3_quot >
                {{(ccre_pkg::MA_W-ccre_pkg::CODE_W){1'b0}}, ccre_pkg::LIN_CODE_MAX}) ?
               ccre_pkg::LIN_CODE_MAX : s3_quot[ccre_pkg::CODE_W-1:0];

    enc_code  = chip_variant ? seg_code : lin_code;
    // Hold the last code when no step was taken
    code_next = s3_written ? enc_code : last_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_code <= '0;
    end else if (adv_out) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        last_code <= code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s3_valid) begin
      out_item.code_written       <= s3_written;
      out_item.charge_code        <= code_next;
      out_item.applied_current_ua <= s3_applied;
      out_item.on_target          <= s3_done;
    end
  end

endmodule

[rtl/ccre_checker.sv]
// ----------------------------------------------------------------------------
// Charge current ramp encoder port checker
// Port-level properties, bound onto the top level.
// ----------------------------------------------------------------------------
`include "charge_current_ramp_encoder_defines.svh"

module ccre_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input ccre_pkg::out_item_t  out_item
);

  // A stalled output transaction holds
  `CCRE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))

  // No step taken means the applied current already sits on the target
  `CCRE_ASSERT_NOW(a_idle_done, clk, rst, out_valid && !out_item.code_written, out_item.on_target)

  // Reset empties the pipeline and frees the input
  `CCRE_ASSERT_NEXT(a_rst_out, clk, 1'b0, rst, !out_valid)
  `CCRE_ASSERT_NEXT(a_rst_in, clk, 1'b0, rst && in_valid, !in_stall)

endmodule

bind charge_current_ramp_encoder ccre_checker u_ccre_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
